>>> hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // Default number of cells in the chain.
    localparam int SPQ_DEPTH = 16;

    // Field widths.
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    // Request opcodes.
    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_POP    = 1'b1
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One input request.
    typedef struct packed {
        t_action                   action;
        logic signed [DATA_W-1:0]  value;
    } t_in_item;

    // One result.
    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  popped_value;
        logic [OCC_W-1:0]          occupancy;
    } t_out_item;

    // Command broadcast to every cell.
    typedef struct packed {
        logic                      ins;
        logic                      pop;
        logic signed [DATA_W-1:0]  value;
    } t_cell_cmd;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic                      gt;
        logic signed [DATA_W-1:0]  value;
    } t_cell_link;

endpackage

>>> hw/rtl/spq_cell.sv
// One cell of the sorted chain: holds one entry and shifts toward either neighbor.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_cmd                 i_cmd,
    input  logic                      i_occupied,
    input  t_cell_link                i_prev,
    input  logic signed [DATA_W-1:0]  i_next_value,
    output t_cell_link                o_link
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     w_gt;

    // The entry stays in place on insert when it is strictly greater than the new value.
    assign w_gt = i_occupied && (r_value > i_cmd.value);

    // On insert, the first cell that is not greater takes the new value and the
    // cells below it take their upper neighbor's entry. On pop, every cell moves up.
    always_comb begin
        n_value = r_value;
        if (i_cmd.ins && !w_gt) begin
            n_value = i_prev.gt ? i_cmd.value : i_prev.value;
        end else if (i_cmd.pop) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.gt    = w_gt;
    assign o_link.value = r_value;

endmodule

>>> hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of cells, the entry count and the result register.
`timescale 1ns / 1ps
// The result is registered: it appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless a held result is stalled; every cell compares and shifts in the same cycle.
// A request is taken while a result waits, as long as that result is taken in the same cycle.
// Reset clears the entry count and the result valid flag; cell contents are left as they are.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    t_out_item            r_out_data;
    t_out_item            n_out_data;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    t_cell_cmd            w_cmd;
    t_cell_link           w_link [DEPTH];

    // A request is taken unless a held result is being stalled.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    // Command broadcast to the chain.
    assign w_cmd.ins   = w_accept && (i_in_data.action == ACT_INSERT) && !w_full;
    assign w_cmd.pop   = w_accept && (i_in_data.action == ACT_POP) && !w_empty;
    assign w_cmd.value = i_in_data.value;

    // Cell 0 holds the top entry; entries descend along the chain.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_link               w_prev;
        logic signed [DATA_W-1:0] w_next_value;

        if (g == 0) begin : g_head
            assign w_prev.gt    = 1'b1;
            assign w_prev.value = '0;
        end else begin : g_body
            assign w_prev = w_link[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_value = w_link[g].value;
        end else begin : g_inner
            assign w_next_value = w_link[g+1].value;
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_prev       (w_prev),
            .i_next_value (w_next_value),
            .o_link       (w_link[g])
        );
    end

    // Next count and result contents.
    always_comb begin
        n_count                 = r_count;
        n_out_data.status       = ST_DONE;
        n_out_data.popped_value = '0;
        if (i_in_data.action == ACT_INSERT) begin
            if (w_full) begin
                n_out_data.status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_out_data.status = ST_EMPTY;
            end else begin
                n_count                 = r_count - 1'b1;
                n_out_data.popped_value = w_link[0].value;
            end
        end
        n_out_data.occupancy = OCC_W'(n_count);
    end

    // Count and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The count never passes the chain length.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // A successful pop returns the entry that was at the top.
    a_pop_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |=> (o_out_data.popped_value == $past(w_link[0].value)))
        else $error("pop did not return the top entry");

    // A rejected insert leaves the count alone.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.action == ACT_INSERT) && w_full)
            |=> (r_count == $past(r_count)))
        else $error("rejected insert changed the count");

    // The top two entries stay ordered.
    a_top_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_link[0].value >= w_link[1].value))
        else $error("top entries out of order");

    // Requests are held off only while a result is pending.
    a_stall_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

endmodule
